### hdl/ultrasonic_echo_ranger_defines.svh
// Assertion macros for the echo ranger
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/uer_pkg.sv
package uer_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned TRIG_W     = 8;
  localparam int unsigned DIST_W     = 15;
  localparam int unsigned PROD_W     = CNT_W + DIST_W;

  localparam logic [CNT_W-1:0]  PRELOW_TICKS  = 16'd2;
  localparam logic [DIST_W-1:0] SPEED_Q16     = 15'd17984;
  localparam logic [DIST_W-1:0] DIST_MAX      = 15'd32767;

  localparam logic [CNT_W-1:0]  TIMEOUT_RST   = 16'd38000;
  localparam logic [TRIG_W-1:0] TRIGGER_RST   = 8'd10;
  localparam logic [DIST_W-1:0] MIN_DIST_RST  = 15'd16;
  localparam logic [DIST_W-1:0] MAX_DIST_RST  = 15'd6400;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PRELOW = 3'd1,
    PH_TRIG   = 3'd2,
    PH_RISE   = 3'd3,
    PH_HIGH   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RISE_TO  = 2'd1,
    ST_FALL_TO  = 2'd2,
    ST_OUT_RNG  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT = 2'd0,
    REG_TRIGGER = 2'd1,
    REG_MIN     = 2'd2,
    REG_MAX     = 2'd3
  } cfg_reg_t;

endpackage

### hdl/uer_in_if.sv
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink (input valid, input start_req, input echo, output ready);
endinterface

### hdl/uer_out_if.sv
interface uer_out_if;
  logic                        valid;
  logic                        ready;
  logic                        trigger;
  logic                        busy_res;
  logic                        done_res;
  logic [1:0]                  status;
  logic [uer_pkg::DIST_W-1:0]  distance_q4;
  logic [uer_pkg::DIST_W-1:0]  last_valid_q4;

  modport source (
    output valid, output trigger, output busy_res, output done_res,
    output status, output distance_q4, output last_valid_q4, input ready
  );
  modport sink (
    input valid, input trigger, input busy_res, input done_res,
    input status, input distance_q4, input last_valid_q4, output ready
  );
endinterface

### hdl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger, one input word per microsecond tick.
// in_ch carries start_req and the sampled echo level; out_ch returns one word
// per input word: trigger pin level, busy, done, status, distance and the
// last in-range distance, all in 1/16 cm.
// cfg_we/cfg_index/cfg_wdata write timeout_ticks, trigger_ticks,
// min_distance_q4 and max_distance_q4 (index 0..3); write only while idle.
// The result word for an accepted input appears on out_ch in the next cycle.
// Throughput: one word per cycle while out_ch is not stalled. The measurement
// state and the result register update together on accept; the
// pulse-to-distance conversion is a single 16x15 multiply in that same cycle.
// in_ch.ready is high whenever the result register is empty or being taken,
// so a stalled receiver holds the pending word and pauses the input side.
// Reset (rst_n low, synchronous) returns to idle, clears the tick counter and
// the last valid distance, restores register defaults (38000, 10, 16, 6400)
// and empties the result register.
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger (
  input  logic                              clk,
  input  logic                              rst_n,
  uer_in_if.sink                            in_ch,
  uer_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [uer_pkg::CNT_W-1:0]  timeout_r;
  logic [uer_pkg::TRIG_W-1:0] trig_len_r;
  logic [uer_pkg::DIST_W-1:0] min_dist_r;
  logic [uer_pkg::DIST_W-1:0] max_dist_r;

  uer_pkg::phase_t            phase_r, phase_nxt;
  logic [uer_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [uer_pkg::DIST_W-1:0] last_r, last_nxt;

  logic                       out_valid_r;
  logic                       trig_r, trig_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  uer_pkg::status_t           status_r, status_nxt;
  logic [uer_pkg::DIST_W-1:0] dist_r, dist_nxt;

  logic                       in_acc;
  logic                       sample_rise;
  logic [uer_pkg::PROD_W-1:0] prod;
  logic [uer_pkg::DIST_W-1:0] dist_calc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign prod = uer_pkg::PROD_W'(cnt_r) * uer_pkg::PROD_W'(uer_pkg::SPEED_Q16);

  always_comb begin
    if (prod[uer_pkg::PROD_W-1:16] > uer_pkg::PROD_W'(uer_pkg::DIST_MAX)) begin
      dist_calc = uer_pkg::DIST_MAX;
    end else begin
      dist_calc = prod[uer_pkg::DIST_W+15:16];
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    trig_nxt    = 1'b0;
    done_nxt    = 1'b0;
    status_nxt  = uer_pkg::ST_OK;
    dist_nxt    = '0;
    sample_rise = 1'b0;

    unique case (phase_r)
      uer_pkg::PH_PRELOW: begin
        if (cnt_r < uer_pkg::PRELOW_TICKS) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          phase_nxt = uer_pkg::PH_TRIG;
          cnt_nxt   = uer_pkg::CNT_W'(1);
          trig_nxt  = 1'b1;
        end
      end
      uer_pkg::PH_TRIG: begin
        if (cnt_r < uer_pkg::CNT_W'(trig_len_r)) begin
          cnt_nxt  = cnt_r + 1'b1;
          trig_nxt = 1'b1;
        end else begin
          phase_nxt   = uer_pkg::PH_RISE;
          cnt_nxt     = '0;
          sample_rise = 1'b1;
        end
      end
      uer_pkg::PH_RISE: begin
        sample_rise = 1'b1;
      end
      uer_pkg::PH_HIGH: begin
        if (!in_ch.echo) begin
          dist_nxt  = dist_calc;
          done_nxt  = 1'b1;
          if (dist_calc < min_dist_r || dist_calc > max_dist_r) begin
            status_nxt = uer_pkg::ST_OUT_RNG;
          end else begin
            last_nxt = dist_calc;
          end
          phase_nxt = uer_pkg::PH_IDLE;
          cnt_nxt   = '0;
        end else if (cnt_r >= timeout_r) begin
          done_nxt   = 1'b1;
          status_nxt = uer_pkg::ST_FALL_TO;
          phase_nxt  = uer_pkg::PH_IDLE;
          cnt_nxt    = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = uer_pkg::PH_IDLE;
        cnt_nxt   = '0;
        if (in_ch.start_req) begin
          phase_nxt = uer_pkg::PH_PRELOW;
          cnt_nxt   = uer_pkg::CNT_W'(1);
        end
      end
    endcase

    if (sample_rise) begin
      if (in_ch.echo) begin
        phase_nxt = uer_pkg::PH_HIGH;
        cnt_nxt   = uer_pkg::CNT_W'(1);
      end else if (cnt_nxt >= timeout_r) begin
        done_nxt   = 1'b1;
        status_nxt = uer_pkg::ST_RISE_TO;
        phase_nxt  = uer_pkg::PH_IDLE;
        cnt_nxt    = '0;
      end else begin
        cnt_nxt = cnt_nxt + 1'b1;
      end
    end

    busy_nxt = (phase_nxt != uer_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= uer_pkg::TIMEOUT_RST;
      trig_len_r <= uer_pkg::TRIGGER_RST;
      min_dist_r <= uer_pkg::MIN_DIST_RST;
      max_dist_r <= uer_pkg::MAX_DIST_RST;
    end else if (cfg_we) begin
      unique case (uer_pkg::cfg_reg_t'(cfg_index))
        uer_pkg::REG_TIMEOUT: timeout_r  <= cfg_wdata[uer_pkg::CNT_W-1:0];
        uer_pkg::REG_TRIGGER: trig_len_r <= cfg_wdata[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_MIN:     min_dist_r <= cfg_wdata[uer_pkg::DIST_W-1:0];
        uer_pkg::REG_MAX:     max_dist_r <= cfg_wdata[uer_pkg::DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= uer_pkg::PH_IDLE;
      cnt_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      trig_r   <= trig_nxt;
      busy_r   <= busy_nxt;
      done_r   <= done_nxt;
      status_r <= status_nxt;
      dist_r   <= dist_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger       = trig_r;
  assign out_ch.busy_res      = busy_r;
  assign out_ch.done_res      = done_r;
  assign out_ch.status        = status_r;
  assign out_ch.distance_q4   = dist_r;
  assign out_ch.last_valid_q4 = last_r;

  `UER_ASSERT_NOW(a_done_idle, out_valid_r && done_r, !busy_r,
    "done word still reports busy")
  `UER_ASSERT_NOW(a_status_done, out_valid_r && status_r != uer_pkg::ST_OK, done_r,
    "status set without done")
  `UER_ASSERT_NOW(a_trig_busy, out_valid_r && trig_r, busy_r && !done_r,
    "trigger high outside a measurement")
  `UER_ASSERT_NEXT(a_start_prelow,
    in_acc && phase_r == uer_pkg::PH_IDLE && in_ch.start_req,
    phase_r == uer_pkg::PH_PRELOW && busy_r,
    "start in idle did not begin a measurement")

endmodule

### dv/echo_ranger_checker.sv
module echo_ranger_checker
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  uer_in_if                     in_mon,
  uer_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           words_due
);

  localparam int unsigned LOW_LEAD_TICKS = 2;
  localparam int unsigned US_TO_Q4_Q16   = 17984;
  localparam int unsigned Q4_CEILING     = 32767;
  localparam int unsigned PRINT_CAP      = 40;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    status_t           status;
    logic [DIST_W-1:0] dist_q4;
    logic [DIST_W-1:0] held;
  } ranger_word_t;

  logic [CNT_W-1:0]  timeout_len;
  logic [TRIG_W-1:0] trigger_len;
  logic [DIST_W-1:0] min_q4;
  logic [DIST_W-1:0] max_q4;

  phase_t            ph;
  logic [CNT_W-1:0]  ticks;
  logic [DIST_W-1:0] held_q4;

  ranger_word_t      tick_results_due[$];
  int unsigned       err_tally = 0;

  assign mismatches = err_tally;

  function automatic logic [DIST_W-1:0] pulse_to_q4(input logic [CNT_W-1:0] n);
    logic [31:0] prod;
    prod = 32'(n) * US_TO_Q4_Q16;
    prod = prod >> 16;
    if (prod > Q4_CEILING) return DIST_W'(Q4_CEILING);
    return prod[DIST_W-1:0];
  endfunction

  task automatic advance_ranger(input logic start_bit, input logic echo_bit,
                                output ranger_word_t w);
    logic              look_for_rise;
    logic [DIST_W-1:0] d;
    w = '0;
    w.status = ST_OK;
    look_for_rise = 1'b0;
    case (ph)
      PH_PRELOW: begin
        if (ticks < CNT_W'(LOW_LEAD_TICKS)) begin
          ticks = ticks + 1'b1;
        end else begin
          ph = PH_TRIG;
          ticks = 1;
          w.trigger = 1'b1;
        end
      end
      PH_TRIG: begin
        if (ticks < CNT_W'(trigger_len)) begin
          ticks = ticks + 1'b1;
          w.trigger = 1'b1;
        end else begin
          ph = PH_RISE;
          ticks = 0;
          look_for_rise = 1'b1;
        end
      end
      PH_RISE: look_for_rise = 1'b1;
      PH_HIGH: begin
        if (!echo_bit) begin
          d = pulse_to_q4(ticks);
          w.done = 1'b1;
          w.dist_q4 = d;
          if (d < min_q4 || d > max_q4) begin
            w.status = ST_OUT_RNG;
          end else begin
            held_q4 = d;
          end
          ph = PH_IDLE;
          ticks = 0;
        end else if (ticks >= timeout_len) begin
          w.done = 1'b1;
          w.status = ST_FALL_TO;
          ph = PH_IDLE;
          ticks = 0;
        end else begin
          ticks = ticks + 1'b1;
        end
      end
      default: begin
        ph = PH_IDLE;
        ticks = 0;
        if (start_bit) begin
          ph = PH_PRELOW;
          ticks = 1;
        end
      end
    endcase
    if (look_for_rise) begin
      if (echo_bit) begin
        ph = PH_HIGH;
        ticks = 1;
      end else if (ticks >= timeout_len) begin
        w.done = 1'b1;
        w.status = ST_RISE_TO;
        ph = PH_IDLE;
        ticks = 0;
      end else begin
        ticks = ticks + 1'b1;
      end
    end
    w.busy = (ph != PH_IDLE);
    w.held = held_q4;
  endtask

  task automatic log_mismatch(input string msg);
    if (err_tally < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
    err_tally = err_tally + 1;
  endtask

  task automatic cmp_field(input string name, input int got, input int want);
    if (got != want) log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    ranger_word_t want;
    ranger_word_t got;
    if (!rst_n) begin
      timeout_len = TIMEOUT_RST;
      trigger_len = TRIGGER_RST;
      min_q4 = MIN_DIST_RST;
      max_q4 = MAX_DIST_RST;
      ph = PH_IDLE;
      ticks = 0;
      held_q4 = 0;
      tick_results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TIMEOUT: timeout_len = cfg_wdata[CNT_W-1:0];
          REG_TRIGGER: trigger_len = cfg_wdata[TRIG_W-1:0];
          REG_MIN:     min_q4 = cfg_wdata[DIST_W-1:0];
          REG_MAX:     max_q4 = cfg_wdata[DIST_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (tick_results_due.size() == 0) begin
          log_mismatch("result word with nothing expected");
        end else begin
          want = tick_results_due.pop_front();
          got.trigger = out_mon.trigger;
          got.busy = out_mon.busy_res;
          got.done = out_mon.done_res;
          got.status = status_t'(out_mon.status);
          got.dist_q4 = out_mon.distance_q4;
          got.held = out_mon.last_valid_q4;
          cmp_field("trigger", got.trigger, want.trigger);
          cmp_field("busy_res", got.busy, want.busy);
          cmp_field("done_res", got.done, want.done);
          cmp_field("status", got.status, want.status);
          cmp_field("distance_q4", got.dist_q4, want.dist_q4);
          cmp_field("last_valid_q4", got.held, want.held);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        advance_ranger(in_mon.start_req, in_mon.echo, want);
        tick_results_due.push_back(want);
      end
    end
    words_due <= tick_results_due.size();
  end

endmodule

### dv/tb_top.sv
module tb_top;
  import uer_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned LONG_HOLD     = 60;
  localparam int unsigned PHASE_TICKS   = 25;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned words_due;
  int unsigned cycle_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned snd_idle_pct = 28;
  int unsigned rcv_idle_pct = 46;
  int unsigned stall_asks = 0;
  int unsigned tmo_now = TIMEOUT_RST;
  int unsigned trig_now = TRIGGER_RST;

  always #10 clk = ~clk;

  uer_in_if  in_ch();
  uer_out_if out_ch();

  ultrasonic_echo_ranger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  echo_ranger_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ultrasonic_echo_ranger] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned served;
    served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_asks != served) begin
        served++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_tick(input logic start_bit, input logic echo_bit);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_req <= start_bit;
    in_ch.echo <= echo_bit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // start, two low ticks and the trigger pulse, then the echo wait and pulse
  task automatic run_ping(input int unsigned wait_len, input int unsigned high_len,
                          input bit noisy);
    int unsigned lead;
    lead = (trig_now == 0) ? 1 : trig_now;
    send_tick(1'b1, 1'($urandom_range(1)));
    repeat (lead + 1) send_tick(noisy && ($urandom_range(9) < 3), 1'($urandom_range(1)));
    repeat (wait_len) send_tick(noisy && ($urandom_range(9) < 3), 1'b0);
    repeat (high_len) send_tick(noisy && ($urandom_range(9) < 3), 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  // drive quiet ticks long enough for any measurement to time out, then drain
  task automatic settle_idle();
    int unsigned lead;
    lead = (trig_now == 0) ? 1 : trig_now;
    repeat (lead + tmo_now + 6) send_tick(1'b0, 1'b0);
    drain_results();
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // upper bits beyond each register width carry junk, the block masks them
  task automatic set_regs(input int unsigned tmo, input int unsigned trig,
                          input int unsigned mn, input int unsigned mx);
    write_reg(REG_TIMEOUT, tmo[15:0]);
    write_reg(REG_TRIGGER, {8'($urandom), trig[7:0]});
    write_reg(REG_MIN, {1'($urandom), mn[14:0]});
    write_reg(REG_MAX, {1'($urandom), mx[14:0]});
    cfg_we <= 1'b0;
    tmo_now = tmo;
    trig_now = trig;
  endtask

  task automatic random_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                              input int unsigned pressure);
    int unsigned mark;
    int unsigned r;
    int unsigned mn;
    bit          pressed;
    settle_idle();
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    mn = $urandom_range(5, 0);
    set_regs($urandom_range(16, 4), $urandom_range(12, 0), mn, $urandom_range(12, mn));
    mark = ticks_sent;
    pressed = 1'b0;
    while (ticks_sent - mark < PHASE_TICKS) begin
      if (!pressed && ticks_sent - mark > 10) begin
        pressed = 1'b1;
        if (pressure == 1) stall_asks++;
        if (pressure == 2) drain_results();
      end
      r = $urandom_range(99);
      if (r < 70) begin
        run_ping($urandom_range(tmo_now, 0), $urandom_range(tmo_now, 1), 1'($urandom_range(1)));
      end else if (r < 85) begin
        run_ping($urandom_range(tmo_now + 3, 0), $urandom_range(tmo_now + 3, 0), 1'b1);
      end else begin
        repeat ($urandom_range(6, 1)) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.start_req <= 1'b0;
    in_ch.echo <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: in-range pulse, starts while busy
    run_ping(3, 60, 1'b1);

    // zero trigger length, open range: rise timeout, fall timeout, ok
    drain_results();
    set_regs(4, 0, 0, 32767);
    run_ping(6, 2, 1'b0);
    run_ping(0, 10, 1'b0);
    run_ping(4, 4, 1'b0);
    run_ping(2, 1, 1'b0);

    // zero timeout: immediate rise timeout, and fall timeout after a rise
    drain_results();
    set_regs(0, 1, 3, 3);
    run_ping(0, 0, 1'b0);
    run_ping(0, 3, 1'b0);

    // min above max, then min and max at the top, then both zero
    drain_results();
    set_regs(40, 3, 5, 2);
    run_ping(1, 10, 1'b0);
    drain_results();
    set_regs(40, 2, 32767, 32767);
    run_ping(0, 20, 1'b0);
    drain_results();
    set_regs(12, 2, 0, 0);
    run_ping(0, 3, 1'b0);

    random_phase(28, 46, 1);
    random_phase(46, 28, 2);
    random_phase(0, 0, 0);

    // widest timeout with a long pulse
    settle_idle();
    set_regs(65535, 12, 0, 32767);
    run_ping(10, 40, 1'b1);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ultrasonic_echo_ranger] OK");
    end else begin
      $display("[ultrasonic_echo_ranger] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/uer_pkg.sv
hdl/uer_in_if.sv
hdl/uer_out_if.sv
hdl/ultrasonic_echo_ranger.sv
dv/echo_ranger_checker.sv
dv/tb_top.sv
